// ===== design/lcsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the table-driven sine/cosine core.
// No dependencies; compiled first.
package lcsc_pkg;

	// Phase is an unsigned fraction of a turn, one turn = 2^PHASE_W
	localparam int PHASE_W = 24;
	localparam logic [PHASE_W-1:0] QUARTER_TURN = 24'h400000;

	// Result is Q1.15
	localparam int VALUE_W   = 16;
	localparam int OUT_FRAC  = 15;
	localparam int VALUE_MAX = 32767;
	localparam int VALUE_MIN = -32768;

	// Request codes
	typedef enum logic {
		REQ_SINE   = 1'b0,
		REQ_COSINE = 1'b1
	} req_t;

	// Table build: pi in Q2.30 and one in Q2.30
	localparam logic [63:0]        PI_Q30  = 64'd3373259426;
	localparam logic signed [63:0] ONE_Q30 = 64'sh40000000;

endpackage

// ===== design/lcsc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on lcsc_pkg.
interface lcsc_req_if;
	import lcsc_pkg::*;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [PHASE_W-1:0] phase;

	modport source(output valid, req_type, phase, input ready);
	modport sink(input valid, req_type, phase, output ready);
endinterface

interface lcsc_res_if;
	import lcsc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source(output valid, value, input ready);
	modport sink(input valid, value, output ready);
endinterface

// ===== design/lcsc_rom_bank.sv =====
`timescale 1ns / 1ps
// One quarter of the interleaved sine ROM: holds every fourth table entry.
// Contents are computed at elaboration; depends on lcsc_pkg.
module lcsc_rom_bank #(
	parameter int TABLE_SIZE  = 4096,
	parameter int SAMPLE_BITS = 16,
	parameter int BANK        = 0
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [$clog2(TABLE_SIZE)-1:0]       idx,
	output logic signed [SAMPLE_BITS-1:0]       rd_s2
);
	import lcsc_pkg::*;

	localparam int AW      = $clog2(TABLE_SIZE);
	localparam int DEPTH   = TABLE_SIZE / 4;
	localparam int QUARTER = TABLE_SIZE / 4;
	localparam logic [63:0] SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
	localparam logic [1:0]  BANK_ID = BANK[1:0];

	typedef logic signed [SAMPLE_BITS-1:0] bank_t [DEPTH];

	// Quarter-wave Taylor sine in Q2.30, folded to a full turn and scaled
	function automatic logic signed [SAMPLE_BITS-1:0] entry(input int unsigned i);
		logic [63:0]        quad;
		logic [63:0]        r;
		logic [63:0]        a;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        s;
		logic [63:0]        mag;
		logic signed [63:0] sum;
		quad = (64'(i) >> (AW - 2)) & 64'd3;
		r    = 64'(i) & 64'(QUARTER - 1);
		a    = quad[0] ? (64'(QUARTER) - r) : r;
		x    = (PI_Q30 * a) >> (AW - 1);
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
		if (sum < 0)
			sum = 64'sd0;
		if (sum > ONE_Q30)
			sum = ONE_Q30;
		s   = 64'(sum);
		mag = (s * SCALE + (64'd1 << 29)) >> 30;
		entry = quad[1] ? SAMPLE_BITS'(64'd0 - mag) : SAMPLE_BITS'(mag);
	endfunction

	function automatic bank_t build_bank();
		bank_t tbl;
		for (int j = 0; j < DEPTH; j++)
			tbl[j] = entry(unsigned'(j * 4 + BANK));
		return tbl;
	endfunction

	localparam bank_t ROM = build_bank();

	// Of the four neighbors idx-1 .. idx+2 exactly one lands in this bank
	logic [1:0]    ofs;
	logic [AW-1:0] tap;
	logic [AW-3:0] addr;

	always_comb begin
		ofs  = BANK_ID - idx[1:0] + 2'd1;
		tap  = idx + AW'(ofs) - AW'(1);
		addr = tap[AW-1:2];
	end

	always_ff @(posedge clk) begin
		if (en)
			rd_s2 <= ROM[addr];
	end

endmodule

// ===== design/lcsc_horner.sv =====
`timescale 1ns / 1ps
// Three Horner iterations h = rnd(h*mu) + c, each a multiply stage then a round/add stage.
// Depends on lcsc_pkg only through the top level's widths.
module lcsc_horner #(
	parameter int HW = 21,
	parameter int FB = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [FB-1:0]               in_mu,
	input  logic signed [3:0][HW-1:0]   in_coef,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [HW-1:0]        out_h
);
	localparam int PW   = HW + FB + 1;
	localparam int NIT  = 3;
	localparam logic [PW:0] HALF = (PW + 1)'(1) << (FB - 1);

	// Per iteration: multiply stage (_sm) and round/add stage (_sa)
	logic                      valid_sm [NIT];
	logic signed [PW-1:0]      prod_sm  [NIT];
	logic [FB-1:0]             mu_sm    [NIT];
	logic signed [3:0][HW-1:0] coef_sm  [NIT];
	logic                      valid_sa [NIT];
	logic signed [HW-1:0]      h_sa     [NIT];
	logic [FB-1:0]             mu_sa    [NIT];
	logic signed [3:0][HW-1:0] coef_sa  [NIT];

	logic                      rdy_sm   [NIT];
	logic                      rdy_sa   [NIT];
	logic                      src_valid[NIT];
	logic signed [HW-1:0]      src_h    [NIT];
	logic [FB-1:0]             src_mu   [NIT];
	logic signed [3:0][HW-1:0] src_coef [NIT];
	logic                      dst_ready[NIT];

	for (genvar k = 0; k < NIT; k++) begin : g_it
		logic signed [PW:0] rsum;
		logic signed [PW:0] rsh;

		if (k == 0) begin : g_first
			assign src_valid[k] = in_valid;
			assign src_h[k]     = $signed(in_coef[0]);
			assign src_mu[k]    = in_mu;
			assign src_coef[k]  = in_coef;
		end else begin : g_next
			assign src_valid[k] = valid_sa[k-1];
			assign src_h[k]     = h_sa[k-1];
			assign src_mu[k]    = mu_sa[k-1];
			assign src_coef[k]  = coef_sa[k-1];
		end

		if (k == NIT - 1) begin : g_last
			assign dst_ready[k] = out_ready;
		end else begin : g_mid
			assign dst_ready[k] = rdy_sm[k+1];
		end

		assign rdy_sa[k] = !valid_sa[k] || dst_ready[k];
		assign rdy_sm[k] = !valid_sm[k] || rdy_sa[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sm[k] <= 1'b0;
				valid_sa[k] <= 1'b0;
			end else begin
				if (rdy_sm[k])
					valid_sm[k] <= src_valid[k];
				if (rdy_sa[k])
					valid_sa[k] <= valid_sm[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_sm[k]) begin
				prod_sm[k] <= PW'(src_h[k]) * PW'($signed({1'b0, src_mu[k]}));
				mu_sm[k]   <= src_mu[k];
				coef_sm[k] <= src_coef[k];
			end
		end

		// Round half up, then add the next coefficient
		always_comb begin
			rsum = {prod_sm[k][PW-1], prod_sm[k]} + $signed(HALF);
			rsh  = rsum >>> FB;
		end

		always_ff @(posedge clk) begin
			if (rdy_sa[k]) begin
				h_sa[k]    <= rsh[HW-1:0] + coef_sm[k][k+1];
				mu_sa[k]   <= mu_sm[k];
				coef_sa[k] <= coef_sm[k];
			end
		end
	end

	assign in_ready  = rdy_sm[0];
	assign out_valid = valid_sa[NIT-1];
	assign out_h     = h_sa[NIT-1];

endmodule

// ===== design/lut_cubic_sine_cosine_core.sv =====
`timescale 1ns / 1ps
// Top level: sine/cosine by table lookup with Catmull-Rom cubic interpolation.
// Depends on lcsc_pkg, lcsc_if, lcsc_rom_bank and lcsc_horner.
//
//   channel | dir | payload                         | transfer when
//   --------+-----+---------------------------------+------------------------
//   req     | in  | req_type (0 sin, 1 cos), phase  | req.valid & req.ready
//   res     | out | value, Q1.15 signed, saturated  | res.valid & res.ready
//
// One transfer per cycle in and out while res.ready stays high; every item passes
// from request to result through the ten register stages (phase, ROM read,
// coefficients, three multiply and round/add pairs, output scaling).
// arst_n clears all stage valid bits; the ROM needs no initialization.
// Each stage holds while its successor is full and stalled; empty stages keep
// filling, so a waiting result does not stop new requests until the pipe is full.
module lut_cubic_sine_cosine_core #(
	parameter int TABLE_SIZE    = 4096,
	parameter int FRACTION_BITS = 12,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lcsc_req_if.sink   req,
	lcsc_res_if.source res
);
	import lcsc_pkg::*;

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int FB = FRACTION_BITS;
	localparam int SB = SAMPLE_BITS;
	// Horner accumulator: bounded by 24 table steps of magnitude 2^(SB-1)
	localparam int HW = SB + 5;
	localparam int SW = HW + 4;

	// ---------------------------------------------------------------
	// Stage 1: apply the cosine offset, split phase into index and fraction
	// ---------------------------------------------------------------
	logic                     valid_s1;
	logic [AW-1:0]            idx_s1;
	logic [FB-1:0]            mu_s1;
	logic                     rdy_s1;
	logic                     rdy_s2;
	logic                     rdy_s3;
	logic                     hor_ready;

	logic [PHASE_W-1:0]       ph;
	logic [PHASE_W+AW-1:0]    ph_wide;

	always_comb begin
		ph      = req.phase + ((req.req_type == REQ_COSINE) ? QUARTER_TURN : '0);
		// index bits past the top of the phase read as zero
		ph_wide = {AW'(0), ph};
	end

	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign req.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rdy_s1)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			idx_s1 <= ph_wide[FB +: AW];
			mu_s1  <= ph[FB-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: read the four neighbors, one from each interleaved bank
	// ---------------------------------------------------------------
	logic                 valid_s2;
	logic [1:0]           lo_s2;
	logic [FB-1:0]        mu_s2;
	logic signed [SB-1:0] rd_s2 [4];

	assign rdy_s2 = !valid_s2 || rdy_s3;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		lcsc_rom_bank #(
			.TABLE_SIZE (TABLE_SIZE),
			.SAMPLE_BITS(SAMPLE_BITS),
			.BANK       (b)
		) u_bank (
			.clk  (clk),
			.en   (rdy_s2),
			.idx  (idx_s1),
			.rd_s2(rd_s2[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (rdy_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			lo_s2 <= idx_s1[1:0];
			mu_s2 <= mu_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: route banks to y0..y3 and form the doubled cubic coefficients
	// ---------------------------------------------------------------
	logic                      valid_s3;
	logic [FB-1:0]             mu_s3;
	logic signed [3:0][HW-1:0] coef_s3;
	logic signed [HW-1:0]      y [4];
	logic [1:0]                sel [4];
	logic signed [3:0][HW-1:0] coef;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			sel[j] = lo_s2 + 2'(j) - 2'd1;
			y[j]   = HW'(rd_s2[sel[j]]);
		end
		coef[0] = y[3] - y[0] + (y[1] <<< 1) + y[1] - (y[2] <<< 1) - y[2];
		coef[1] = (y[0] <<< 1) - (y[1] <<< 2) - y[1] + (y[2] <<< 2) - y[3];
		coef[2] = y[2] - y[0];
		coef[3] = y[1] <<< 1;
	end

	assign rdy_s3 = !valid_s3 || hor_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (rdy_s3)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			coef_s3 <= coef;
			mu_s3   <= mu_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stages 4..9: Horner evaluation of the cubic at mu
	// ---------------------------------------------------------------
	logic                 hor_valid;
	logic signed [HW-1:0] hor_h;
	logic                 rdy_s10;

	lcsc_horner #(
		.HW(HW),
		.FB(FB)
	) u_horner (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.in_ready (hor_ready),
		.in_mu    (mu_s3),
		.in_coef  (coef_s3),
		.out_valid(hor_valid),
		.out_ready(rdy_s10),
		.out_h    (hor_h)
	);

	// ---------------------------------------------------------------
	// Stage 10: scale the doubled result to Q1.15 and saturate
	// ---------------------------------------------------------------
	logic                      valid_s10;
	logic signed [VALUE_W-1:0] value_s10;
	logic signed [SW-1:0]      scaled;
	logic signed [VALUE_W-1:0] sat;

	if (SB > OUT_FRAC) begin : g_down
		localparam int SH = SB - OUT_FRAC;
		logic signed [SW-1:0] biased;
		assign biased = SW'(hor_h) + SW'(1 << (SH - 1));
		assign scaled = biased >>> SH;
	end else if (SB == OUT_FRAC) begin : g_same
		assign scaled = SW'(hor_h);
	end else begin : g_up
		assign scaled = SW'(hor_h) <<< (OUT_FRAC - SB);
	end

	always_comb begin
		if (scaled > SW'(VALUE_MAX))
			sat = VALUE_W'(VALUE_MAX);
		else if (scaled < SW'(VALUE_MIN))
			sat = VALUE_W'(VALUE_MIN);
		else
			sat = scaled[VALUE_W-1:0];
	end

	assign rdy_s10 = !valid_s10 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s10 <= 1'b0;
		else if (rdy_s10)
			valid_s10 <= hor_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy_s10)
			value_s10 <= sat;
	end

	assign res.valid = valid_s10;
	assign res.value = value_s10;

endmodule
